@@ design/ffha_pkg.sv @@
// Shared types for the first-fit heap allocator: request, response and sequencer state.
package ffha_pkg;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_SHRINK = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] req_size;
        logic [12:0] block_offset;
    } req_t;

    typedef struct packed {
        logic [12:0] result_offset;
        status_t     status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUND,
        S_SIZE,
        S_DECIDE,
        S_AWALK,
        S_LWALK,
        S_M0,
        S_M1,
        S_ML,
        S_ML1,
        S_ML2,
        S_OUT
    } state_t;

endpackage

@@ design/first_fit_heap_allocator.sv @@
// First-fit boundary-tag heap allocator: sequencer, header memory and result register.
// Steps: round the size, scale it to the alignment and check the request, then walk the
// header chain one header at a time, then split and merge updates; the result is then
// held until taken. One request at a time: req_ready is high only while idle. Reset is
// immediate: entry 0 and the end sentinel read as their reset values through a flag
// and a fixed decode, so no clearing pass runs.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES      = 4096,
    parameter int ALIGN_BYTES     = 4,
    parameter int HEADER_BYTES    = 8,
    parameter int MIN_SPLIT_BYTES = 12
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_item,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_item
);

    localparam int OW  = $clog2(HEAP_BYTES + 1);
    localparam int AW  = $clog2(HEAP_BYTES);
    localparam int XW  = 18;
    localparam int SW  = 17;
    localparam int RS  = 17 + $clog2(ALIGN_BYTES);
    localparam int RMW = 19;
    localparam int RM  = (2 ** RS + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PW  = SW + RMW;

    localparam logic [OW-1:0] HEAP_O = OW'(HEAP_BYTES);
    localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
    localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] MIN_X  = XW'(MIN_SPLIT_BYTES);

    typedef struct packed {
        logic [OW-1:0] next;
        logic [OW-1:0] prev;
        logic          used;
    } hdr_t;

    hdr_t mem [HEAP_BYTES];

    state_t state_reg, state_next;
    mode_t  mode_reg;
    logic [15:0]   req_reg;
    logic [12:0]   bo_reg;
    logic [PW-1:0] prod_reg, prod_next;
    logic [SW-1:0] sz_reg, sz_next;
    logic [OW-1:0] ptr_reg, ptr_next;
    logic [OW-1:0] h_reg, h_next;
    logic [OW-1:0] m_reg, m_next;
    logic [OW-1:0] cn_reg, cn_next;
    logic [OW-1:0] cp_reg, cp_next;
    logic [OW-1:0] lf_reg, lf_next;
    logic          nomerge_reg, nomerge_next;
    logic          rdone_reg, rdone_next;
    logic [12:0]   res_off_reg, res_off_next;
    status_t       res_st_reg, res_st_next;
    logic          v0_reg;

    logic          mem_we, mem_re;
    logic [OW-1:0] mem_wa, mem_ra, ra_q;
    hdr_t          mem_wd, rd_raw, d;

    logic [XW-1:0] sz_x, bo_x, ptr_x, h_x, nx_x;
    logic [SW-1:0] q;
    logic zero_req, too_big, no_free, bad_ofs, fit, at_h, past_h, slack;
    logic m1_merge, nx_end;

    assign sz_x  = XW'(sz_reg);
    assign bo_x  = XW'(bo_reg);
    assign ptr_x = XW'(ptr_reg);
    assign h_x   = XW'(h_reg);
    assign nx_x  = XW'(d.next);
    assign q     = SW'(prod_reg >> RS);

    assign zero_req = (req_reg == 16'd0);
    assign too_big  = (sz_x > HEAP_X);
    assign no_free  = (lf_reg >= HEAP_O);
    assign bad_ofs  = (bo_x < HDR_X) || ((bo_x - HDR_X) >= HEAP_X);
    assign fit      = !d.used && (nx_x >= ptr_x + HDR_X + HDR_X + sz_x);
    assign at_h     = (ptr_reg == h_reg);
    assign past_h   = (ptr_reg > h_reg);
    assign slack    = (h_x + HDR_X + HDR_X + MIN_X + sz_x) < nx_x;
    assign nx_end   = (d.next >= HEAP_O);
    assign m1_merge = !nomerge_reg && !rdone_reg && !d.used;

    always_comb
    begin
        if (ra_q == HEAP_O)
        begin
            d = '{next: HEAP_O, prev: HEAP_O, used: 1'b1};
        end
        else if (ra_q == '0 && !v0_reg)
        begin
            d = '{next: HEAP_O, prev: '0, used: 1'b0};
        end
        else
        begin
            d = rd_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && mem_wa != HEAP_O)
        begin
            mem[mem_wa[AW-1:0]] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_raw <= mem[mem_ra[AW-1:0]];
            ra_q   <= mem_ra;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (req_valid) state_next = S_ROUND;
            S_ROUND:  state_next = S_SIZE;
            S_SIZE:   state_next = S_DECIDE;
            S_DECIDE:
            begin
                unique case (mode_reg)
                    MODE_ALLOC:  state_next = (zero_req || too_big || no_free) ? S_OUT : S_AWALK;
                    MODE_FREE:   state_next = bad_ofs ? S_OUT : S_LWALK;
                    MODE_SHRINK: state_next = (too_big || bad_ofs) ? S_OUT : S_LWALK;
                    default:     state_next = S_OUT;
                endcase
            end
            S_AWALK:
            begin
                priority if (fit)    state_next = S_M0;
                else if (nx_end)     state_next = S_OUT;
                else                 state_next = S_AWALK;
            end
            S_LWALK:
            begin
                priority if (at_h)
                begin
                    if (!d.used)                    state_next = S_OUT;
                    else if (mode_reg == MODE_FREE) state_next = S_M0;
                    else                            state_next = slack ? S_M0 : S_OUT;
                end
                else if (past_h || nx_end)          state_next = S_OUT;
                else                                state_next = S_LWALK;
            end
            S_M0:
            begin
                priority if (cn_reg != HEAP_O) state_next = S_M1;
                else if (nomerge_reg)          state_next = S_OUT;
                else                           state_next = S_ML;
            end
            S_M1:
            begin
                priority if (m1_merge) state_next = S_M0;
                else if (nomerge_reg)  state_next = S_OUT;
                else                   state_next = S_ML;
            end
            S_ML:  state_next = (cp_reg != m_reg) ? S_ML1 : S_OUT;
            S_ML1: state_next = (!d.used && cn_reg != HEAP_O) ? S_ML2 : S_OUT;
            S_ML2: state_next = S_OUT;
            S_OUT: if (rsp_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        prod_next    = prod_reg;
        sz_next      = sz_reg;
        ptr_next     = ptr_reg;
        h_next       = h_reg;
        m_next       = m_reg;
        cn_next      = cn_reg;
        cp_next      = cp_reg;
        lf_next      = lf_reg;
        nomerge_next = nomerge_reg;
        rdone_next   = rdone_reg;
        res_off_next = res_off_reg;
        res_st_next  = res_st_reg;
        mem_we       = 1'b0;
        mem_wa       = m_reg;
        mem_wd       = '{next: cn_reg, prev: cp_reg, used: 1'b0};
        mem_re       = 1'b0;
        mem_ra       = cn_reg;
        req_ready    = (state_reg == S_IDLE);
        rsp_valid    = (state_reg == S_OUT);

        unique case (state_reg)
            S_ROUND:
            begin
                prod_next = PW'(SW'(req_reg) + SW'(ALIGN_BYTES - 1)) * PW'(RM);
            end
            S_SIZE:
            begin
                sz_next = SW'(q * SW'(ALIGN_BYTES));
            end
            S_DECIDE:
            begin
                res_off_next = '0;
                h_next       = OW'(bo_x - HDR_X);
                unique case (mode_reg)
                    MODE_ALLOC:
                    begin
                        res_st_next = zero_req ? ST_IGNORED : ST_NOSPACE;
                        ptr_next    = lf_reg;
                        mem_ra      = lf_reg;
                        mem_re      = !(zero_req || too_big || no_free);
                    end
                    MODE_FREE:
                    begin
                        res_st_next = ST_IGNORED;
                        ptr_next    = '0;
                        mem_ra      = '0;
                        mem_re      = !bad_ofs;
                    end
                    MODE_SHRINK:
                    begin
                        res_st_next = too_big ? ST_NOSPACE : ST_IGNORED;
                        ptr_next    = '0;
                        mem_ra      = '0;
                        mem_re      = !(too_big || bad_ofs);
                    end
                    default:
                    begin
                        res_st_next = ST_IGNORED;
                    end
                endcase
            end
            S_AWALK:
            begin
                if (fit)
                begin
                    m_next       = OW'(ptr_x + HDR_X + sz_x);
                    cn_next      = d.next;
                    cp_next      = ptr_reg;
                    nomerge_next = 1'b1;
                    rdone_next   = 1'b0;
                    mem_we       = 1'b1;
                    mem_wa       = ptr_reg;
                    mem_wd       = '{next: OW'(ptr_x + HDR_X + sz_x), prev: d.prev, used: 1'b1};
                    if (ptr_reg == lf_reg)
                    begin
                        lf_next = OW'(ptr_x + HDR_X + sz_x);
                    end
                    res_off_next = 13'(ptr_x + HDR_X);
                    res_st_next  = ST_DONE;
                end
                else
                begin
                    ptr_next = d.next;
                    mem_ra   = d.next;
                    mem_re   = !nx_end;
                end
            end
            S_LWALK:
            begin
                if (at_h)
                begin
                    if (d.used)
                    begin
                        res_st_next  = ST_DONE;
                        nomerge_next = 1'b0;
                        rdone_next   = 1'b0;
                        if (mode_reg == MODE_FREE)
                        begin
                            res_off_next = '0;
                            m_next       = h_reg;
                            cn_next      = d.next;
                            cp_next      = d.prev;
                            if (h_reg < lf_reg)
                            begin
                                lf_next = h_reg;
                            end
                        end
                        else
                        begin
                            res_off_next = bo_reg;
                            if (slack)
                            begin
                                m_next  = OW'(h_x + HDR_X + sz_x);
                                cn_next = d.next;
                                cp_next = h_reg;
                                mem_we  = 1'b1;
                                mem_wa  = h_reg;
                                mem_wd  = '{next: OW'(h_x + HDR_X + sz_x), prev: d.prev,
                                            used: 1'b1};
                                if (OW'(h_x + HDR_X + sz_x) < lf_reg)
                                begin
                                    lf_next = OW'(h_x + HDR_X + sz_x);
                                end
                            end
                        end
                    end
                end
                else if (!past_h)
                begin
                    ptr_next = d.next;
                    mem_ra   = d.next;
                    mem_re   = !nx_end;
                end
            end
            S_M0:
            begin
                mem_we = 1'b1;
                mem_re = (cn_reg != HEAP_O);
            end
            S_M1:
            begin
                if (m1_merge)
                begin
                    if (lf_reg == cn_reg)
                    begin
                        lf_next = m_reg;
                    end
                    cn_next    = d.next;
                    rdone_next = 1'b1;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wa = cn_reg;
                    mem_wd = '{next: d.next, prev: m_reg, used: d.used};
                end
            end
            S_ML:
            begin
                mem_ra = cp_reg;
                mem_re = (cp_reg != m_reg);
            end
            S_ML1:
            begin
                if (!d.used)
                begin
                    if (lf_reg == m_reg)
                    begin
                        lf_next = cp_reg;
                    end
                    mem_we = 1'b1;
                    mem_wa = cp_reg;
                    mem_wd = '{next: cn_reg, prev: d.prev, used: 1'b0};
                    mem_re = (cn_reg != HEAP_O);
                end
            end
            S_ML2:
            begin
                mem_we = 1'b1;
                mem_wa = cn_reg;
                mem_wd = '{next: d.next, prev: cp_reg, used: d.used};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lf_reg    <= '0;
            v0_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lf_reg    <= lf_next;
            if (mem_we && mem_wa == '0)
            begin
                v0_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            mode_reg <= req_item.mode;
            req_reg  <= req_item.req_size;
            bo_reg   <= req_item.block_offset;
        end
        prod_reg    <= prod_next;
        sz_reg      <= sz_next;
        ptr_reg     <= ptr_next;
        h_reg       <= h_next;
        m_reg       <= m_next;
        cn_reg      <= cn_next;
        cp_reg      <= cp_next;
        nomerge_reg <= nomerge_next;
        rdone_reg   <= rdone_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
    end

    assign rsp_item.result_offset = res_off_reg;
    assign rsp_item.status        = res_st_reg;

endmodule

@@ verif/tb_top.sv @@
// Testbench for the first-fit heap allocator: predictor, stimulus tasks and response checker.
module tb_top;
    import ffha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP    = 4096;
    localparam int ALIGN   = 4;
    localparam int HDR     = 8;
    localparam int MINSPL  = 12;
    localparam int WD_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_item;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_item;

    first_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
    );

    int unsigned blk_next [0:HEAP];
    int unsigned blk_prev [0:HEAP];
    bit          blk_used [0:HEAP];
    int unsigned low_free;
    rsp_t        expected_rsps [$];
    int unsigned live_blocks [$];
    int          fail_count;
    bit          quiet;
    int          idle_cnt;
    int          ready_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clampo(int unsigned i);
        return (i > HEAP) ? HEAP : i;
    endfunction

    function automatic int unsigned align_up(int unsigned s);
        return (s % ALIGN != 0) ? s + ALIGN - (s % ALIGN) : s;
    endfunction

    function automatic bit on_chain_used(int unsigned h);
        int unsigned p;
        int unsigned g;
        p = 0;
        g = 0;
        while (p < HEAP && g <= HEAP)
        begin
            if (p == h) return blk_used[p];
            if (p > h) return 1'b0;
            p = clampo(blk_next[p]);
            g++;
        end
        return 1'b0;
    endfunction

    function automatic void coalesce(int unsigned m);
        int unsigned n;
        int unsigned p;
        m = clampo(m);
        n = clampo(blk_next[m]);
        if (n != m && !blk_used[n] && n != HEAP)
        begin
            if (low_free == n) low_free = m;
            blk_next[m] = blk_next[n];
            blk_prev[clampo(blk_next[n])] = m;
        end
        p = clampo(blk_prev[m]);
        if (p != m && !blk_used[p])
        begin
            if (low_free == m) low_free = p;
            blk_next[p] = blk_next[m];
            blk_prev[clampo(blk_next[m])] = p;
        end
    endfunction

    function automatic void heap_reset();
        for (int i = 0; i <= HEAP; i++)
        begin
            blk_next[i] = 0;
            blk_prev[i] = 0;
            blk_used[i] = 1'b0;
        end
        blk_next[0] = HEAP;
        blk_next[HEAP] = HEAP;
        blk_prev[HEAP] = HEAP;
        blk_used[HEAP] = 1'b1;
        low_free = 0;
    endfunction

    function automatic rsp_t mk_rsp(int unsigned ofs, status_t st);
        rsp_t r;
        r.result_offset = ofs[12:0];
        r.status = st;
        return r;
    endfunction

    function automatic rsp_t heap_alloc(int unsigned req);
        int unsigned sz;
        int unsigned ptr;
        int unsigned nx;
        int unsigned p2;
        int unsigned g;
        if (req == 0) return mk_rsp(0, ST_IGNORED);
        sz = align_up(req);
        if (sz > HEAP) return mk_rsp(0, ST_NOSPACE);
        ptr = clampo(low_free);
        g = 0;
        while (ptr < HEAP && g <= HEAP)
        begin
            nx = clampo(blk_next[ptr]);
            if (!blk_used[ptr] && nx >= ptr + 2 * HDR + sz)
            begin
                p2 = ptr + HDR + sz;
                blk_prev[p2] = ptr;
                blk_next[p2] = nx;
                blk_next[ptr] = p2;
                if (nx != HEAP) blk_prev[nx] = p2;
                blk_used[p2] = 1'b0;
                blk_used[ptr] = 1'b1;
                if (ptr == low_free)
                begin
                    g = 0;
                    while (blk_used[clampo(low_free)] && low_free != HEAP && g <= HEAP)
                    begin
                        low_free = clampo(blk_next[clampo(low_free)]);
                        g++;
                    end
                end
                return mk_rsp(ptr + HDR, ST_DONE);
            end
            ptr = nx;
            g++;
        end
        return mk_rsp(0, ST_NOSPACE);
    endfunction

    function automatic rsp_t heap_free(int unsigned bo);
        int unsigned h;
        if (bo < HDR) return mk_rsp(0, ST_IGNORED);
        h = bo - HDR;
        if (h >= HEAP || !on_chain_used(h)) return mk_rsp(0, ST_IGNORED);
        blk_used[h] = 1'b0;
        if (h < low_free) low_free = h;
        coalesce(h);
        return mk_rsp(0, ST_DONE);
    endfunction

    function automatic rsp_t heap_shrink(int unsigned req, int unsigned bo);
        int unsigned sz;
        int unsigned h;
        int unsigned nx;
        int unsigned cur;
        int unsigned p2;
        sz = align_up(req);
        if (sz > HEAP) return mk_rsp(0, ST_NOSPACE);
        if (bo < HDR) return mk_rsp(0, ST_IGNORED);
        h = bo - HDR;
        if (h >= HEAP || !on_chain_used(h)) return mk_rsp(0, ST_IGNORED);
        nx = clampo(blk_next[h]);
        cur = nx - h - HDR;
        if (sz + HDR + MINSPL < cur)
        begin
            p2 = h + HDR + sz;
            blk_used[p2] = 1'b0;
            blk_next[p2] = nx;
            blk_prev[p2] = h;
            blk_next[h] = p2;
            if (nx != HEAP) blk_prev[nx] = p2;
            if (p2 < low_free) low_free = p2;
            coalesce(p2);
        end
        return mk_rsp(bo, ST_DONE);
    endfunction

    function automatic rsp_t heap_predict(req_t r);
        case (r.mode)
            MODE_ALLOC:  return heap_alloc(r.req_size);
            MODE_FREE:   return heap_free(r.block_offset);
            MODE_SHRINK: return heap_shrink(r.req_size, r.block_offset);
            default:     return mk_rsp(0, ST_IGNORED);
        endcase
    endfunction

    task automatic send_request(mode_t m, int unsigned sz, int unsigned ofs);
        req_t r;
        rsp_t e;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        r.mode = m;
        r.req_size = sz[15:0];
        r.block_offset = ofs[12:0];
        req_item <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        e = heap_predict(r);
        expected_rsps.push_back(e);
        if (m == MODE_ALLOC && e.status == ST_DONE) live_blocks.push_back(e.result_offset);
        if (m == MODE_FREE && e.status == ST_DONE)
            foreach (live_blocks[i])
                if (live_blocks[i] == ofs)
                begin
                    live_blocks.delete(i);
                    break;
                end
        @(negedge clk);
    endtask

    function automatic int unsigned pick_live();
        if (live_blocks.size() == 0) return $urandom_range(0, 8191);
        return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    endfunction

    always @(posedge clk)
    begin
        rsp_t e;
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected item offset=%0d status=%0d",
                       rsp_item.result_offset, rsp_item.status);
                fail_count++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (rsp_item.result_offset !== e.result_offset)
                begin
                    $error("result_offset expected %0d actual %0d",
                           e.result_offset, rsp_item.result_offset);
                    fail_count++;
                end
                if (rsp_item.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, rsp_item.status);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (quiet)
        begin
            ready_gap = 0;
            rsp_ready <= 1'b1;
        end
        else if (ready_gap > 0)
        begin
            ready_gap--;
            rsp_ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            ready_gap = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !rst_n) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_ALLOC, 65535, 0);
        send_request(MODE_ALLOC, 4097, 0);
        send_request(MODE_ALLOC, 1, 0);
        send_request(MODE_ALLOC, 100, 0);
        send_request(MODE_ALLOC, 4096, 0);
        send_request(MODE_ALLOC, 37, 0);
        send_request(MODE_FREE, 0, 0);
        send_request(MODE_FREE, 0, 4);
        send_request(MODE_FREE, 0, 8191);
        send_request(MODE_FREE, 0, 4096 + HDR);
        send_request(MODE_FREE, 0, 20);
        send_request(MODE_SHRINK, 65535, 20);
        send_request(MODE_SHRINK, 4, 20);
        send_request(MODE_SHRINK, 96, 20);
        send_request(MODE_SHRINK, 8, 0);
        send_request(MODE_FREE, 0, 8);
        send_request(MODE_FREE, 0, 8);
        send_request(MODE_SHRINK, 4, 8);
        send_request(MODE_NOP, 16'hFFFF, 13'h1FFF);
        send_request(MODE_ALLOC, 4000, 0);
        send_request(MODE_ALLOC, 200, 0);
    endtask

    task automatic test_random(int n, bit drain);
        int unsigned k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (drain && live_blocks.size() > 0) send_request(MODE_FREE, 0, pick_live());
            else if (k < 40)
                send_request(MODE_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                             : $urandom_range(1, 300), 0);
            else if (k < 70) send_request(MODE_FREE, $urandom_range(0, 65535), pick_live());
            else if (k < 85)
                send_request(MODE_SHRINK, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                             : $urandom_range(0, 200), pick_live());
            else if (k < 95)
                send_request(mode_t'($urandom_range(1, 2)), $urandom_range(0, 65535),
                             $urandom_range(0, 8191));
            else send_request(MODE_NOP, $urandom_range(0, 65535), $urandom_range(0, 8191));
        end
    endtask

    initial
    begin
        int w;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_item = '0;
        rsp_ready = 1'b0;
        fail_count = 0;
        quiet = 1'b0;
        idle_cnt = 0;
        ready_gap = 0;
        heap_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(500, 1'b0);
        test_random(40, 1'b1);
        test_random(500, 1'b0);
        quiet = 1'b1;
        test_random(200, 1'b0);
        req_valid <= 1'b0;
        w = 0;
        while (expected_rsps.size() != 0 && w < WD_LIMIT)
        begin
            @(posedge clk);
            w++;
        end
        repeat (50) @(posedge clk);
        if (fail_count == 0 && expected_rsps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ filelist.f @@
design/ffha_pkg.sv
design/first_fit_heap_allocator.sv
verif/tb_top.sv
